// File: design/rtpq_pkg.sv
// rtpq_pkg: shared types, sizes and codes for the remaining-time priority queue
// used by rtpq_cell and remaining_time_priority_queue_top; no dependencies
package rtpq_pkg;

  // queue geometry
  localparam int DEPTH     = 16;
  localparam int TIME_BITS = 16;
  localparam int KEY_W     = TIME_BITS + 1;
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int ID_W      = 8;

  // operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_REMOVE = 1'b1;

  // error codes
  localparam logic [1:0] ERR_OK    = 2'd0;
  localparam logic [1:0] ERR_EMPTY = 2'd1;
  localparam logic [1:0] ERR_FULL  = 2'd2;

  // input word
  typedef struct packed {
    logic                 func;
    logic [ID_W-1:0]      process_id;
    logic [15:0]          run_time;
    logic [15:0]          elapsed_time;
    logic [15:0]          remaining_time;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [ID_W-1:0]      removed_id;
    logic                 removed_valid;
    logic [15:0]          front_remaining;
    logic [CNT_W-1:0]     count;
    logic [1:0]           error_code;
  } out_word_t;

  // one stored entry
  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [ID_W-1:0]         id;
    logic [15:0]             rem;
  } entry_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic insert;
    logic pop;
  } cell_ctl_t;

endpackage

// File: design/rtpq_cell.sv
// rtpq_cell: one slot of the sorted chain; compares, keeps, shifts or loads
// depends on rtpq_pkg
module rtpq_cell (
  input  logic               clk,
  input  rtpq_pkg::cell_ctl_t ctl,
  input  rtpq_pkg::entry_t   new_entry,
  input  rtpq_pkg::entry_t   left_entry,
  input  logic               left_le,
  input  rtpq_pkg::entry_t   right_entry,
  input  logic               occ,
  output logic               le,
  output rtpq_pkg::entry_t   entry_nxt,
  output rtpq_pkg::entry_t   entry_r
);

  // this slot holds a key not above the new one, so it stays in place
  assign le = occ && ($signed(entry_r.key) <= $signed(new_entry.key));

  // next content: keep, load the new word, shift right or shift left
  always_comb begin
    entry_nxt = entry_r;
    if (ctl.insert) begin
      if (le) begin
        entry_nxt = entry_r;
      end else if (left_le) begin
        entry_nxt = new_entry;
      end else begin
        entry_nxt = left_entry;
      end
    end else if (ctl.pop) begin
      entry_nxt = right_entry;
    end
  end

  // slot storage
  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

// File: design/remaining_time_priority_queue_top.sv
// remaining_time_priority_queue_top: top level, chain of rtpq_cell slots,
// entry count and result register; depends on rtpq_pkg and rtpq_cell
//
// Sorted priority queue of up to rtpq_pkg::DEPTH process entries, ordered
// ascending by the signed key run_time minus elapsed_time, taken on arrival;
// equal keys keep arrival order. An insert word (func 0) is rejected with
// error 2 when full; a remove word (func 1) pops the front entry and returns
// its id, or flags error 1 when empty. Every result word carries the count and
// the front entry's remaining time (0 when empty). For each word, every slot
// compares its key with the new one and shifts to its neighbor in the same
// cycle, so one word is accepted per clock while the result register is free
// or being drained. The result is registered and appears in the cycle after
// the word is accepted. No clearing pass after reset.
module remaining_time_priority_queue_top (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  rtpq_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output rtpq_pkg::out_word_t out_data
);

  logic [rtpq_pkg::CNT_W-1:0] count_r;
  logic [rtpq_pkg::CNT_W-1:0] count_nxt;
  logic                       out_valid_r;
  rtpq_pkg::out_word_t        out_data_r;
  rtpq_pkg::out_word_t        out_data_nxt;
  logic                       in_accept;
  logic                       is_full;
  logic                       is_empty;
  rtpq_pkg::cell_ctl_t        ctl;
  rtpq_pkg::entry_t           new_entry;
  rtpq_pkg::entry_t           slot_r   [rtpq_pkg::DEPTH];
  rtpq_pkg::entry_t           slot_nxt [rtpq_pkg::DEPTH];
  logic [rtpq_pkg::DEPTH-1:0] slot_le;
  logic [rtpq_pkg::DEPTH-1:0] slot_occ;

  // handshake: take a word whenever the result register is free or draining
  assign in_ready  = !out_valid_r || out_ready;
  assign in_accept = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign is_full  = (count_r == rtpq_pkg::CNT_W'(rtpq_pkg::DEPTH));
  assign is_empty = (count_r == '0);

  // command for the chain
  assign ctl.insert = in_accept && (in_data.func == rtpq_pkg::FUNC_INSERT) && !is_full;
  assign ctl.pop    = in_accept && (in_data.func == rtpq_pkg::FUNC_REMOVE) && !is_empty;

  // new entry with its key
  assign new_entry.key = $signed({1'b0, in_data.run_time})
                       - $signed({1'b0, in_data.elapsed_time});
  assign new_entry.id  = in_data.process_id;
  assign new_entry.rem = in_data.remaining_time;

  // chain of slots
  for (genvar i = 0; i < rtpq_pkg::DEPTH; i++) begin : g_slot
    rtpq_pkg::entry_t left_e;
    rtpq_pkg::entry_t right_e;
    logic             left_le_i;

    assign slot_occ[i] = (rtpq_pkg::CNT_W'(i) < count_r);

    if (i == 0) begin : g_first
      assign left_e    = new_entry;
      assign left_le_i = 1'b1;
    end else begin : g_inner
      assign left_e    = slot_r[i-1];
      assign left_le_i = slot_le[i-1];
    end

    if (i == rtpq_pkg::DEPTH - 1) begin : g_last
      assign right_e = slot_r[i];
    end else begin : g_mid
      assign right_e = slot_r[i+1];
    end

    rtpq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  (left_e),
      .left_le     (left_le_i),
      .right_entry (right_e),
      .occ         (slot_occ[i]),
      .le          (slot_le[i]),
      .entry_nxt   (slot_nxt[i]),
      .entry_r     (slot_r[i])
    );
  end

  // count update
  always_comb begin
    count_nxt = count_r;
    if (ctl.insert) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  // result word, built from the post-step state
  always_comb begin
    out_data_nxt.removed_id      = '0;
    out_data_nxt.removed_valid   = 1'b0;
    out_data_nxt.error_code      = rtpq_pkg::ERR_OK;
    out_data_nxt.count           = count_nxt;
    out_data_nxt.front_remaining = (count_nxt != '0) ? slot_nxt[0].rem : 16'd0;
    if (in_data.func == rtpq_pkg::FUNC_INSERT) begin
      if (is_full) begin
        out_data_nxt.error_code = rtpq_pkg::ERR_FULL;
      end
    end else begin
      if (is_empty) begin
        out_data_nxt.error_code = rtpq_pkg::ERR_EMPTY;
      end else begin
        out_data_nxt.removed_id    = slot_r[0].id;
        out_data_nxt.removed_valid = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (in_accept) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      out_data_r <= out_data_nxt;
    end
  end

`ifndef ASSERT_OFF
  // count never passes the capacity
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= rtpq_pkg::CNT_W'(rtpq_pkg::DEPTH))
    else $error("entry count above capacity");

  // the two front slots stay in key order
  a_front_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r >= rtpq_pkg::CNT_W'(2)) |-> ($signed(slot_r[0].key) <= $signed(slot_r[1].key)))
    else $error("front slots out of order");

  // a rejected insert leaves the count alone
  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && (in_data.func == rtpq_pkg::FUNC_INSERT) && is_full)
      |=> (count_r == $past(count_r)))
    else $error("count changed on rejected insert");

  // a returned id never comes with an error
  a_removed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.removed_valid) |-> (out_data_r.error_code == rtpq_pkg::ERR_OK))
    else $error("removed word flagged with error");
`endif

endmodule
